// File: design/rrtq_pkg.sv
// ----------------------------------------------------------------------------
// rrtq_pkg
// Shared types and constants for the round-robin thread queue scheduler.
// ----------------------------------------------------------------------------
package rrtq_pkg;

   localparam int SLOTS     = 16;
   localparam int SLOT_BITS = $clog2(SLOTS);
   localparam int LINK_BITS = $clog2(SLOTS + 1);
   localparam int ID_BITS   = 16;
   localparam int PRIO_BITS = 8;
   localparam int TAG_BITS  = 8;
   localparam int CMD_BITS  = 3;
   localparam int PRIO_OUT_BITS = 9;

   localparam logic [LINK_BITS-1:0] NIL = LINK_BITS'(SLOTS);

   localparam logic [CMD_BITS-1:0] CMD_PEND    = 3'd0;
   localparam logic [CMD_BITS-1:0] CMD_READY   = 3'd1;
   localparam logic [CMD_BITS-1:0] CMD_RUN     = 3'd2;
   localparam logic [CMD_BITS-1:0] CMD_REMOVE  = 3'd3;
   localparam logic [CMD_BITS-1:0] CMD_FIND    = 3'd4;
   localparam logic [CMD_BITS-1:0] CMD_MAXPRIO = 3'd5;

   typedef enum logic [1:0] {
      ST_ABSENT  = 2'd0,
      ST_PENDING = 2'd1,
      ST_READY   = 2'd2,
      ST_RUNNING = 2'd3
   } slot_state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;       // capture request, clear result
      logic exec;       // apply single-slot command (pend, ready, run)
      logic walk_start; // set walk pointer to head of the selected list
      logic walk_ready; // walk the ready list instead of pending
      logic walk_step;  // examine current walk entry, advance
      logic remove_run; // check running slot for remove
      logic unlink_hit; // unlink the slot found by the walk, mark absent
      logic finish;     // compute next thread and present result
   } rrtq_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic walk_done;  // pointer null, step budget spent, or find or remove hit
      logic hit;        // walk matched: the id for remove, the tag for find
   } rrtq_status_type;

endpackage

// File: design/rrtq_datapath.sv
// ----------------------------------------------------------------------------
// rrtq_datapath
// Slot table, list links, list heads and the result register.
// ----------------------------------------------------------------------------
module rrtq_datapath
   import rrtq_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  rrtq_cmd_type                cmd,
   output rrtq_status_type             status,
   input  logic [CMD_BITS-1:0]         req_command,
   input  logic [3:0]                  req_slot,
   input  logic [ID_BITS-1:0]          req_thread_id,
   input  logic [PRIO_BITS-1:0]        req_priority_req,
   input  logic [TAG_BITS-1:0]         req_mutex_tag,
   output logic                        rsp_found,
   output logic [3:0]                  rsp_found_slot,
   output logic signed [PRIO_OUT_BITS-1:0] rsp_top_priority,
   output logic                        rsp_next_valid,
   output logic [3:0]                  rsp_next_slot
);

   slot_state_type          state_ff [SLOTS];
   logic [ID_BITS-1:0]      ident_ff [SLOTS];
   logic [PRIO_BITS-1:0]    prio_ff  [SLOTS];
   logic [TAG_BITS-1:0]     tag_ff   [SLOTS];
   logic [LINK_BITS-1:0]    fwd_ff   [SLOTS];
   logic [LINK_BITS-1:0]    bwd_ff   [SLOTS];
   logic [LINK_BITS-1:0]    pend_first_ff, pend_last_ff, ready_first_ff, ready_last_ff;
   logic [LINK_BITS-1:0]    run_ff;

   logic [CMD_BITS-1:0]     command_ff;
   logic [3:0]              slot_ff;
   logic [ID_BITS-1:0]      id_ff;
   logic [PRIO_BITS-1:0]    prioreq_ff;
   logic [TAG_BITS-1:0]     mtag_ff;

   logic [LINK_BITS-1:0]    walk_ff;
   logic [LINK_BITS-1:0]    count_ff;
   logic                    hit_ff;
   logic                    walk_ready_ff;

   logic                    found_ff;
   logic [3:0]              fslot_ff;
   logic signed [PRIO_OUT_BITS-1:0] maxp_ff;
   logic                    nvalid_ff;
   logic [3:0]              nslot_ff;

   // Request slot decode
   logic                    in_range;
   logic [SLOT_BITS-1:0]    s_idx;
   slot_state_type          s_state;
   logic [SLOT_BITS-1:0]    w_idx;
   logic                    w_valid;
   logic                    w_match;
   logic [SLOT_BITS-1:0]    h_idx;
   logic [LINK_BITS-1:0]    nxt;

   assign in_range = ({1'b0, slot_ff} < LINK_BITS'(SLOTS));
   assign s_idx    = SLOT_BITS'(slot_ff);
   assign s_state  = state_ff[s_idx];
   assign w_idx    = SLOT_BITS'(walk_ff);
   assign w_valid  = (walk_ff != NIL);
   assign w_match  = (command_ff == CMD_REMOVE) ? (ident_ff[w_idx] == id_ff)
                                                : (tag_ff[w_idx] == mtag_ff);
   assign h_idx    = SLOT_BITS'(fslot_ff);

   assign status.walk_done = !w_valid || (count_ff == LINK_BITS'(SLOTS)) ||
                             ((command_ff != CMD_MAXPRIO) && hit_ff);
   assign status.hit = hit_ff;

   assign nxt = (ready_first_ff != NIL) ? ready_first_ff : run_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         command_ff <= req_command;
         slot_ff    <= req_slot;
         id_ff      <= req_thread_id;
         prioreq_ff <= req_priority_req;
         mtag_ff    <= req_mutex_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) state_ff[i] <= ST_ABSENT;
         pend_first_ff  <= NIL;
         pend_last_ff   <= NIL;
         ready_first_ff <= NIL;
         ready_last_ff  <= NIL;
         run_ff         <= NIL;
         found_ff       <= 1'b0;
         fslot_ff       <= '0;
         maxp_ff        <= '1;
         hit_ff         <= 1'b0;
         nvalid_ff      <= 1'b0;
         nslot_ff       <= '0;
      end else begin
         if (cmd.load) begin
            found_ff <= 1'b0;
            fslot_ff <= '0;
            maxp_ff  <= '1;
            hit_ff   <= 1'b0;
         end
         if (cmd.exec && in_range) begin
            unique case (command_ff)
               CMD_PEND: begin
                  if (s_state == ST_RUNNING) begin
                     run_ff        <= NIL;
                     fwd_ff[s_idx] <= NIL;
                     bwd_ff[s_idx] <= pend_last_ff;
                     if (pend_last_ff != NIL) fwd_ff[SLOT_BITS'(pend_last_ff)] <= {1'b0, s_idx};
                     else pend_first_ff <= {1'b0, s_idx};
                     pend_last_ff    <= {1'b0, s_idx};
                     tag_ff[s_idx]   <= mtag_ff;
                     state_ff[s_idx] <= ST_PENDING;
                     found_ff        <= 1'b1;
                     fslot_ff        <= slot_ff;
                  end
               end
               CMD_READY: begin
                  if (s_state != ST_READY) begin
                     // Unlink from pending; a self-link never arises, so
                     // the append writes below take precedence safely.
                     if (s_state == ST_PENDING) begin
                        if (bwd_ff[s_idx] != NIL)
                           fwd_ff[SLOT_BITS'(bwd_ff[s_idx])] <= fwd_ff[s_idx];
                        else pend_first_ff <= fwd_ff[s_idx];
                        if (fwd_ff[s_idx] != NIL)
                           bwd_ff[SLOT_BITS'(fwd_ff[s_idx])] <= bwd_ff[s_idx];
                        else pend_last_ff <= bwd_ff[s_idx];
                     end else if (s_state == ST_RUNNING) begin
                        run_ff <= NIL;
                     end else begin
                        ident_ff[s_idx] <= id_ff;
                        prio_ff[s_idx]  <= prioreq_ff;
                     end
                     fwd_ff[s_idx] <= NIL;
                     bwd_ff[s_idx] <= ready_last_ff;
                     if (ready_last_ff != NIL) fwd_ff[SLOT_BITS'(ready_last_ff)] <= {1'b0, s_idx};
                     else ready_first_ff <= {1'b0, s_idx};
                     ready_last_ff   <= {1'b0, s_idx};
                     state_ff[s_idx] <= ST_READY;
                     found_ff        <= 1'b1;
                     fslot_ff        <= slot_ff;
                  end
               end
               CMD_RUN: begin
                  if (s_state == ST_READY) begin
                     if (bwd_ff[s_idx] != NIL)
                        fwd_ff[SLOT_BITS'(bwd_ff[s_idx])] <= fwd_ff[s_idx];
                     else ready_first_ff <= fwd_ff[s_idx];
                     if (fwd_ff[s_idx] != NIL)
                        bwd_ff[SLOT_BITS'(fwd_ff[s_idx])] <= bwd_ff[s_idx];
                     else ready_last_ff <= bwd_ff[s_idx];
                     run_ff          <= {1'b0, s_idx};
                     state_ff[s_idx] <= ST_RUNNING;
                     found_ff        <= 1'b1;
                     fslot_ff        <= slot_ff;
                  end
               end
               default: ;
            endcase
         end
         if (cmd.walk_step && w_valid) begin
            if (w_match) begin
               priority if (command_ff == CMD_MAXPRIO) begin
                  if ($signed({1'b0, prio_ff[w_idx]}) > maxp_ff) begin
                     maxp_ff  <= $signed({1'b0, prio_ff[w_idx]});
                     found_ff <= 1'b1;
                     fslot_ff <= 4'(w_idx);
                  end
               end else if (command_ff == CMD_FIND) begin
                  found_ff <= 1'b1;
                  fslot_ff <= 4'(w_idx);
                  hit_ff   <= 1'b1;
               end else begin
                  fslot_ff <= 4'(w_idx);
                  hit_ff   <= 1'b1;
               end
            end
         end
         if (cmd.remove_run) begin
            if (run_ff != NIL && ident_ff[SLOT_BITS'(run_ff)] == id_ff) begin
               state_ff[SLOT_BITS'(run_ff)] <= ST_ABSENT;
               run_ff   <= NIL;
               found_ff <= 1'b1;
               fslot_ff <= 4'(run_ff);
            end
         end
         if (cmd.unlink_hit) begin
            if (bwd_ff[h_idx] != NIL) fwd_ff[SLOT_BITS'(bwd_ff[h_idx])] <= fwd_ff[h_idx];
            else if (walk_ready_ff) ready_first_ff <= fwd_ff[h_idx];
            else pend_first_ff <= fwd_ff[h_idx];
            if (fwd_ff[h_idx] != NIL) bwd_ff[SLOT_BITS'(fwd_ff[h_idx])] <= bwd_ff[h_idx];
            else if (walk_ready_ff) ready_last_ff <= bwd_ff[h_idx];
            else pend_last_ff <= bwd_ff[h_idx];
            state_ff[h_idx] <= ST_ABSENT;
            found_ff <= 1'b1;
         end
         if (cmd.finish) begin
            nvalid_ff <= (nxt != NIL);
            nslot_ff  <= (nxt != NIL) ? 4'(nxt) : 4'd0;
         end
      end
   end

   // Walk pointer and step budget
   always_ff @(posedge clock) begin
      if (cmd.walk_start) begin
         walk_ready_ff <= cmd.walk_ready;
         walk_ff       <= cmd.walk_ready ? ready_first_ff : pend_first_ff;
         count_ff      <= '0;
      end else if (cmd.walk_step && w_valid) begin
         walk_ff  <= fwd_ff[w_idx];
         count_ff <= count_ff + 1'b1;
      end
   end

   assign rsp_found        = found_ff;
   assign rsp_found_slot   = fslot_ff;
   assign rsp_top_priority = maxp_ff;
   assign rsp_next_valid   = nvalid_ff;
   assign rsp_next_slot    = nslot_ff;

endmodule

// File: design/rrtq_control.sv
// ----------------------------------------------------------------------------
// rrtq_control
// Sequencer for one command: capture, execute or walk, then present result.
// ----------------------------------------------------------------------------
module rrtq_control
   import rrtq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [CMD_BITS-1:0] req_command,
   output rrtq_cmd_type        cmd,
   input  rrtq_status_type     status
);

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_DECODE  = 8'b0000_0010,
      S_WALK    = 8'b0000_0100,
      S_REMRDY  = 8'b0000_1000,
      S_WALKRDY = 8'b0001_0000,
      S_REMOVE  = 8'b0010_0000,
      S_FINISH  = 8'b0100_0000,
      S_OUT     = 8'b1000_0000
   } fsm_type;

   fsm_type             state_ff, state_in;
   logic [CMD_BITS-1:0] op_ff;
   logic                accept;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (accept) op_ff <= req_command;
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            priority if (op_ff == CMD_PEND || op_ff == CMD_READY || op_ff == CMD_RUN) begin
               cmd.exec = 1'b1;
               state_in = S_FINISH;
            end else if (op_ff == CMD_REMOVE || op_ff == CMD_FIND ||
                         op_ff == CMD_MAXPRIO) begin
               cmd.walk_start = 1'b1;
               state_in = S_WALK;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_WALK: begin
            if (status.walk_done) begin
               if (op_ff == CMD_REMOVE) begin
                  if (status.hit) state_in = S_REMOVE;
                  else begin
                     cmd.walk_start = 1'b1;
                     cmd.walk_ready = 1'b1;
                     state_in = S_WALKRDY;
                  end
               end else state_in = S_FINISH;
            end else cmd.walk_step = 1'b1;
         end
         S_WALKRDY: begin
            if (status.walk_done) begin
               if (status.hit) state_in = S_REMOVE;
               else state_in = S_REMRDY;
            end else cmd.walk_step = 1'b1;
         end
         S_REMRDY: begin
            cmd.remove_run = 1'b1;
            state_in = S_FINISH;
         end
         S_REMOVE: begin
            cmd.unlink_hit = 1'b1;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

endmodule

// File: design/round_robin_thread_queues.sv
// ----------------------------------------------------------------------------
// round_robin_thread_queues
// Thread slot table with FIFO pending and ready lists and a running slot.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   command, slot, thread_id,
//                                            priority_req, mutex_tag
// rsp_      out        rsp_valid/rsp_stall   found, found_slot, top_priority,
//                                            next_valid, next_slot
//
// One transaction at a time; req_stall stays high until the result leaves.
// Pend, ready and run execute in decode; these and unused codes then pass
// through finish to the output state. Find and highest priority walk the
// pending list one entry per cycle (a find hit stops early). Remove walks the
// pending list, then the ready list, then checks the running slot, up to a hit.
// Synchronous reset empties all lists and marks every slot absent.
// While rsp_stall is high the result holds in its register.
// ----------------------------------------------------------------------------
module round_robin_thread_queues
   import rrtq_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [CMD_BITS-1:0]         req_command,
   input  logic [3:0]                  req_slot,
   input  logic [ID_BITS-1:0]          req_thread_id,
   input  logic [PRIO_BITS-1:0]        req_priority_req,
   input  logic [TAG_BITS-1:0]         req_mutex_tag,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_found,
   output logic [3:0]                  rsp_found_slot,
   output logic signed [PRIO_OUT_BITS-1:0] rsp_top_priority,
   output logic                        rsp_next_valid,
   output logic [3:0]                  rsp_next_slot
);

   rrtq_cmd_type    cmd;
   rrtq_status_type status;

   // Sequence each transaction.
   rrtq_control u_control (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .req_command (req_command),
      .cmd         (cmd),
      .status      (status)
   );

   // Hold slot table, links and result.
   rrtq_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_command      (req_command),
      .req_slot         (req_slot),
      .req_thread_id    (req_thread_id),
      .req_priority_req (req_priority_req),
      .req_mutex_tag    (req_mutex_tag),
      .rsp_found        (rsp_found),
      .rsp_found_slot   (rsp_found_slot),
      .rsp_top_priority (rsp_top_priority),
      .rsp_next_valid   (rsp_next_valid),
      .rsp_next_slot    (rsp_next_slot)
   );

endmodule
